### rtl/esp3fd_pkg.sv
// esp3fd_pkg: shared types, constants and the crc8 helper of the esp3 deframer
// no dependencies; used by every module of the deframer but esp3fd_ram
package esp3fd_pkg;

    // frame format
    localparam logic [7:0]  SYNC_BYTE        = 8'h55;
    localparam int          HDR_BYTES        = 6;
    localparam int          LEN_W            = 17;
    localparam int          DEF_BUFFER_BYTES = 64;
    localparam logic [15:0] DEF_TIMEOUT      = 16'd100;

    // input beat kinds carried in tuser
    localparam logic [1:0] MODE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SYNC_RD,
        S_SYNC_CHK,
        S_HDR_RD,
        S_HDR_CHK,
        S_LEN,
        S_DAT_RD,
        S_DAT_CHK,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_RS_INIT,
        S_RS_RD,
        S_RS_CHK
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic idx_zero;
        logic idx_one;
        logic idx_six;
        logic idx_inc;
        logic crc_clr;
        logic crc_upd;
        logic hdr_ld;
        logic drop_one;
        logic drop_idx;
        logic drop_full;
        logic fill_clr;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_byte;
        logic fill_zero;
        logic rd_sync;
        logic fill_lt_hdr;
        logic hdr_last;
        logic too_big;
        logic fill_lt_full;
        logic hdr_ok;
        logic crc_match;
        logic idx_at_crc;
        logic idx_ge_fill;
        logic out_free;
    } t_status;

    // crc8, poly 0x07, msb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/esp3_frame_deframer.sv
// esp3_frame_deframer: top level of the esp3 receive deframer
// depends on esp3fd_pkg, esp3fd_ctrl, esp3fd_dpath (and esp3fd_ram below it)
//
// channel   dir  handshake                   beat contents
// s_axis    in   i_s_axis_tvalid/o_..tready  tdata: data_byte; tuser: mode
// m_axis    out  o_m_axis_tvalid/i_..tready  tdata: payload_byte, packet_type;
//                                            tuser: in_optional; tlast: last
// cfg       in   i_cfg_valid/o_cfg_ready     inter_byte_timeout, always ready
//
// tick, flush and unused beats are taken in idle and start no framing pass. a byte
// beat starts a framing pass that visits buffer bytes, each visit one read of the
// buffer ram with a registered read port: skipped bytes, the header, crc bytes,
// emitted bytes and bytes scanned in a resync.
// synchronous active low reset empties the buffer; no clearing pass is needed.
// a stalled result waits in the output register; emission and the input both
// wait until it is taken, since the framing pass has not finished.
module esp3_frame_deframer import esp3fd_pkg::*; #(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] payload_byte, [15:8] packet_type
    output logic        o_m_axis_tuser,   // [0] in_optional
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    esp3fd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    esp3fd_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_s_axis_tuser),
        .i_byte         (i_s_axis_tdata),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_payload_byte (o_m_axis_tdata[7:0]),
        .o_in_optional  (o_m_axis_tuser),
        .o_packet_type  (o_m_axis_tdata[15:8]),
        .o_last         (o_m_axis_tlast)
    );

    assign o_cfg_ready = 1'b1;

endmodule

### rtl/esp3fd_ram.sv
// esp3fd_ram: generic simple dual port ram, one write port, registered read
// no dependencies
module esp3fd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/esp3fd_ctrl.sv
// esp3fd_ctrl: sequencer for sync search, header and crc checks, emit and resync
// depends on esp3fd_pkg
module esp3fd_ctrl import esp3fd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept   = 1'b1;
                    o_cmd.idx_zero = 1'b1;
                    if (i_status.is_byte) begin
                        n_state = S_SYNC_RD;
                    end
                end
            end
            S_SYNC_RD: begin
                n_state = i_status.fill_zero ? S_IDLE : S_SYNC_CHK;
            end
            S_SYNC_CHK: begin
                if (!i_status.rd_sync) begin
                    o_cmd.drop_one = 1'b1;
                    n_state        = S_SYNC_RD;
                end else if (i_status.fill_lt_hdr) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_one = 1'b1;
                    o_cmd.crc_clr = 1'b1;
                    n_state       = S_HDR_RD;
                end
            end
            S_HDR_RD: begin
                n_state = S_HDR_CHK;
            end
            S_HDR_CHK: begin
                o_cmd.hdr_ld = 1'b1;
                if (i_status.hdr_last) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_HDR_RD;
                end
            end
            S_LEN: begin
                if (i_status.too_big) begin
                    n_state = S_RS_INIT;
                end else if (i_status.fill_lt_full) begin
                    n_state = S_IDLE;
                end else if (!i_status.hdr_ok) begin
                    n_state = S_RS_INIT;
                end else begin
                    o_cmd.idx_six = 1'b1;
                    o_cmd.crc_clr = 1'b1;
                    n_state       = S_DAT_RD;
                end
            end
            S_DAT_RD: begin
                n_state = S_DAT_CHK;
            end
            S_DAT_CHK: begin
                if (i_status.idx_at_crc) begin
                    if (i_status.crc_match) begin
                        o_cmd.idx_six = 1'b1;
                        n_state       = S_EMIT_RD;
                    end else begin
                        n_state = S_RS_INIT;
                    end
                end else begin
                    o_cmd.crc_upd = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_DAT_RD;
                end
            end
            S_EMIT_RD: begin
                if (i_status.idx_at_crc) begin
                    o_cmd.drop_full = 1'b1;
                    o_cmd.idx_zero  = 1'b1;
                    n_state         = S_SYNC_RD;
                end else begin
                    n_state = S_EMIT_WAIT;
                end
            end
            S_EMIT_WAIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                    n_state        = S_EMIT_RD;
                end
            end
            S_RS_INIT: begin
                o_cmd.idx_one = 1'b1;
                n_state       = S_RS_RD;
            end
            S_RS_RD: begin
                if (i_status.idx_ge_fill) begin
                    o_cmd.fill_clr = 1'b1;
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_SYNC_RD;
                end else begin
                    n_state = S_RS_CHK;
                end
            end
            S_RS_CHK: begin
                if (i_status.rd_sync) begin
                    o_cmd.drop_idx = 1'b1;
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_SYNC_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RS_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/esp3fd_dpath.sv
// esp3fd_dpath: circular frame buffer, counters, crc, length math and output register
// depends on esp3fd_pkg and esp3fd_ram
module esp3fd_dpath import esp3fd_pkg::*; #(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_byte,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_in_optional,
    output logic [7:0]  o_packet_type,
    output logic        o_last
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam logic [FW:0]      BUF_S = (FW + 1)'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0] BUF_L = LEN_W'(BUFFER_BYTES);

    logic [AW-1:0]    r_head;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    r_idx;
    logic [15:0]      r_idle;
    logic [15:0]      r_tmo;
    logic [7:0]       r_crc;
    logic [15:0]      r_dl;
    logic [7:0]       r_ol;
    logic [7:0]       r_ptype;
    logic             r_hok;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_oopt;
    logic [7:0]       r_optype;
    logic             r_olast;

    logic [7:0]       rdata;
    logic [FW-1:0]    fill_eff;
    logic             wr_en;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [LEN_W-1:0] crc_at;
    logic [LEN_W-1:0] full;
    logic [LEN_W-1:0] idx_l;
    logic [FW-1:0]    drop_n;
    logic [AW-1:0]    head_adv;

    // add an offset to a buffer pointer with wrap around
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [FW-1:0] o);
        logic [FW:0] s;
        s = (FW + 1)'(p) + (FW + 1)'(o);
        if (s >= BUF_S) begin
            s = s - BUF_S;
        end
        return s[AW-1:0];
    endfunction

    // byte arrival: timeout clear, append when room
    assign fill_eff = (r_fill != '0 && r_idle > r_tmo) ? '0 : r_fill;
    assign wr_en    = i_cmd.accept && i_mode == MODE_BYTE && fill_eff < FW'(BUFFER_BYTES);
    assign waddr    = wrap_add(r_head, fill_eff);
    assign raddr    = wrap_add(r_head, r_idx);

    esp3fd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (i_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // frame length math
    assign crc_at = LEN_W'(HDR_BYTES) + LEN_W'(r_dl) + LEN_W'(r_ol);
    assign full   = crc_at + LEN_W'(1);
    assign idx_l  = LEN_W'(r_idx);

    // amount removed from the front
    always_comb begin
        if (i_cmd.drop_full) begin
            drop_n = full[FW-1:0];
        end else if (i_cmd.drop_idx) begin
            drop_n = r_idx;
        end else begin
            drop_n = FW'(1);
        end
    end
    assign head_adv = wrap_add(r_head, drop_n);

    // control state: pointers, fill, idle ticks, timeout register, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_idle   <= '0;
            r_tmo    <= DEF_TIMEOUT;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tmo <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                case (i_mode)
                    MODE_BYTE: begin
                        r_idle <= '0;
                        r_fill <= wr_en ? fill_eff + FW'(1) : fill_eff;
                    end
                    MODE_TICK: begin
                        if (r_idle != 16'hFFFF) begin
                            r_idle <= r_idle + 16'd1;
                        end
                    end
                    MODE_FLUSH: begin
                        r_fill <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.drop_one || i_cmd.drop_idx || i_cmd.drop_full) begin
                r_head <= head_adv;
                r_fill <= r_fill - drop_n;
            end
            if (i_cmd.fill_clr) begin
                r_fill <= '0;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // scan index, crc and header fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_one) begin
            r_idx <= FW'(1);
        end else if (i_cmd.idx_six) begin
            r_idx <= FW'(HDR_BYTES);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + FW'(1);
        end
        if (i_cmd.crc_clr) begin
            r_crc <= '0;
        end else if (i_cmd.crc_upd) begin
            r_crc <= crc8_byte(r_crc, rdata);
        end else if (i_cmd.hdr_ld && r_idx != FW'(5)) begin
            r_crc <= crc8_byte(r_crc, rdata);
        end
        if (i_cmd.hdr_ld) begin
            if (r_idx == FW'(1)) r_dl[15:8] <= rdata;
            if (r_idx == FW'(2)) r_dl[7:0]  <= rdata;
            if (r_idx == FW'(3)) r_ol       <= rdata;
            if (r_idx == FW'(4)) r_ptype    <= rdata;
            if (r_idx == FW'(5)) r_hok      <= (r_crc == rdata);
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_obyte  <= rdata;
            r_oopt   <= idx_l >= LEN_W'(HDR_BYTES) + LEN_W'(r_dl);
            r_optype <= r_ptype;
            r_olast  <= idx_l + LEN_W'(1) == crc_at;
        end
    end

    // status toward the controller
    always_comb begin
        o_status.is_byte      = i_mode == MODE_BYTE;
        o_status.fill_zero    = r_fill == '0;
        o_status.rd_sync      = rdata == SYNC_BYTE;
        o_status.fill_lt_hdr  = r_fill < FW'(HDR_BYTES);
        o_status.hdr_last     = r_idx == FW'(5);
        o_status.too_big      = full > BUF_L;
        o_status.fill_lt_full = LEN_W'(r_fill) < full;
        o_status.hdr_ok       = r_hok;
        o_status.crc_match    = r_crc == rdata;
        o_status.idx_at_crc   = idx_l == crc_at;
        o_status.idx_ge_fill  = r_idx >= r_fill;
        o_status.out_free     = !r_ovalid || i_out_ready;
    end

    assign o_out_valid    = r_ovalid;
    assign o_payload_byte = r_obyte;
    assign o_in_optional  = r_oopt;
    assign o_packet_type  = r_optype;
    assign o_last         = r_olast;

endmodule

### rtl/esp3fd_checker.sv
// esp3fd_checker: port level assertions for the esp3 deframer, bound to the top level
// depends on esp3fd_pkg and esp3_frame_deframer
module esp3fd_checker import esp3fd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [15:0] i_cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a byte always starts a framing pass, so input is held off next cycle
    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_BYTE
            |=> !o_s_axis_tready)
        else $error("input taken right after a byte");

    // ticks, flushes and unused beats never produce results or stall input
    a_tick_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser != MODE_BYTE
            |=> o_s_axis_tready)
        else $error("non byte beat started a framing pass");

endmodule

bind esp3_frame_deframer esp3fd_checker u_esp3fd_checker (.*);

### tb/tb.sv
// tb: self-checking testbench of esp3_frame_deframer with its own frame predictor
// depends on esp3fd_pkg and the rtl of esp3_frame_deframer
`timescale 1ns / 100ps

module tb;
    import esp3fd_pkg::*;

    localparam int BUF_BYTES   = 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [7:0] payload;
        logic       opt;
        logic [7:0] ptype;
        logic       last;
    } t_payload_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    esp3_frame_deframer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser),
        .o_m_axis_tlast(o_m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [7:0]      rx_buf [BUF_BYTES];
    int              rx_fill;
    int              rx_idle;
    int              rx_timeout;
    t_payload_beat   expected_beats [$];
    int              error_count;
    int              cycle_count;
    int              hold_off_cycles;
    bit              stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] crc_over(logic [7:0] bytes [$]);
        logic [7:0] c;
        c = 8'h00;
        foreach (bytes[i]) begin
            c = c ^ bytes[i];
            for (int b = 0; b < 8; b++)
                c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] buf_crc(int from, int upto);
        logic [7:0] q [$];
        for (int i = from; i < upto; i++) q = {q, rx_buf[i]};
        return crc_over(q);
    endfunction

    function automatic void drop_bytes(int n);
        if (n >= rx_fill) begin
            rx_fill = 0;
            return;
        end
        for (int i = 0; i < rx_fill - n; i++) rx_buf[i] = rx_buf[i + n];
        rx_fill -= n;
    endfunction

    function automatic void resync_buf();
        for (int i = 1; i < rx_fill; i++)
            if (rx_buf[i] == SYNC_BYTE) begin
                drop_bytes(i);
                return;
            end
        rx_fill = 0;
    endfunction

    // cut one frame if possible; returns 1 when a valid frame was removed
    function automatic bit cut_frame();
        int dlen, olen, full, crc_pos;
        t_payload_beat pb;
        forever begin
            while (rx_fill > 0 && rx_buf[0] != SYNC_BYTE) drop_bytes(1);
            if (rx_fill < HDR_BYTES) return 0;
            dlen = {rx_buf[1], rx_buf[2]};
            olen = rx_buf[3];
            full = HDR_BYTES + dlen + olen + 1;
            if (full > BUF_BYTES) begin
                resync_buf();
                continue;
            end
            if (rx_fill < full) return 0;
            crc_pos = HDR_BYTES + dlen + olen;
            if (buf_crc(1, 5) != rx_buf[5] || buf_crc(HDR_BYTES, crc_pos) != rx_buf[crc_pos])
            begin
                resync_buf();
                continue;
            end
            for (int i = 0; i < dlen + olen; i++) begin
                pb.payload = rx_buf[HDR_BYTES + i];
                pb.opt     = (i >= dlen);
                pb.ptype   = rx_buf[4];
                pb.last    = (i + 1 == dlen + olen);
                expected_beats = {expected_beats, pb};
            end
            drop_bytes(full);
            return 1;
        end
    endfunction

    function automatic void predict_beat(logic [1:0] mode, logic [7:0] data);
        case (mode)
            MODE_TICK: if (rx_idle < 65535) rx_idle++;
            MODE_FLUSH: rx_fill = 0;
            MODE_BYTE: begin
                if (rx_fill != 0 && rx_idle > rx_timeout) rx_fill = 0;
                rx_idle = 0;
                if (rx_fill < BUF_BYTES) begin
                    rx_buf[rx_fill] = data;
                    rx_fill++;
                end
                while (cut_frame()) ;
            end
            default: ;
        endcase
    endfunction

    // send one beat and model it at acceptance
    task automatic send_beat(logic [1:0] mode, logic [7:0] data);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_beat(mode, data);
        // random gap between bursts
        if ($urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_bytes(logic [7:0] q [$]);
        foreach (q[i]) send_beat(MODE_BYTE, q[i]);
    endtask

    // build a well formed frame, optionally corrupting a crc
    function automatic void make_frame(ref logic [7:0] q [$], input logic [7:0] ptype,
                                       input int dlen, input int olen, input bit bad);
        logic [7:0] hdr [$];
        logic [7:0] body [$];
        hdr = '{dlen[15:8], dlen[7:0], olen[7:0], ptype};
        for (int i = 0; i < dlen + olen; i++) body = {body, 8'($urandom_range(0, 255))};
        q = {q, SYNC_BYTE};
        q = {q, hdr};
        q = {q, crc_over(hdr) ^ (bad && $urandom_range(0, 1) ? 8'h01 : 8'h00)};
        q = {q, body};
        q = {q, crc_over(body) ^ (bad ? 8'h80 : 8'h00)};
    endfunction

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        rx_timeout = value;
    endtask

    // check each result beat
    always @(posedge i_clk) begin
        t_payload_beat exp_b;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat exp none act %h", $time, o_m_axis_tdata);
                error_count++;
            end else begin
                exp_b = expected_beats.pop_front();
                if (o_m_axis_tdata != {exp_b.ptype, exp_b.payload}
                    || o_m_axis_tuser != exp_b.opt || o_m_axis_tlast != exp_b.last) begin
                    $display("%0t: mismatch exp data %h opt %b last %b act data %h opt %b last %b",
                             $time, {exp_b.ptype, exp_b.payload}, exp_b.opt, exp_b.last,
                             o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_enable)
            i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            i_m_axis_tready <= 1'b1;
    end

    task automatic test_directed();
        logic [7:0] q [$];
        q = '{8'h00, 8'hFF, 8'hAA};             // leading garbage
        make_frame(q, 8'h01, 1, 0, 0);
        make_frame(q, 8'hFF, 0, 0, 0);          // empty payload
        make_frame(q, 8'h00, 2, 1, 1);          // bad crc
        make_frame(q, 8'h0A, 0, 2, 0);          // optional only
        send_bytes(q);
        send_beat(MODE_UNUSED, 8'hFF);
        send_beat(MODE_TICK, 8'h00);
        send_beat(MODE_FLUSH, 8'h00);
        q = '{SYNC_BYTE, 8'hFF, 8'hFF, 8'hFF};  // oversized
        send_bytes(q);
        q = {};
        make_frame(q, 8'h05, 57, 0, 0);         // largest frame
        send_bytes(q);
        wait_drained();
    endtask

    task automatic test_timeout();
        logic [7:0] q [$];
        write_timeout(16'd0);
        make_frame(q, 8'h22, 2, 0, 0);
        send_bytes(q[0:2]);
        send_beat(MODE_TICK, 8'h00);            // expires partial frame
        send_bytes(q);
        wait_drained();
        write_timeout(16'hFFFF);
        for (int i = 0; i < 20; i++) send_beat(MODE_TICK, 8'h00);
        wait_drained();
    endtask

    task automatic test_backpressure();
        logic [7:0] q [$];
        hold_off_cycles = 3000;
        for (int k = 0; k < 4; k++) make_frame(q, 8'($urandom_range(0, 255)), 10, 3, 0);
        send_bytes(q);
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        logic [7:0] q [$];
        int sent;
        sent = 0;
        stall_enable = 1'b1;
        while (sent < n_items) begin
            q = {};
            case ($urandom_range(0, 9))
                0: q = {q, 8'($urandom_range(0, 255))};
                1: begin
                    send_beat(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
                    sent++;
                end
                2: begin
                    make_frame(q, 8'($urandom_range(0, 255)), $urandom_range(0, 8),
                               $urandom_range(0, 4), 1);
                    q = q[0:$urandom_range(0, q.size() - 1)];
                end
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        make_frame(q, 8'($urandom_range(0, 255)), $urandom_range(40, 50),
                                   $urandom_range(0, 7), 0);
                    else
                        make_frame(q, 8'($urandom_range(0, 255)), $urandom_range(0, 8),
                                   $urandom_range(0, 4), $urandom_range(0, 5) == 0);
                end
            endcase
            send_bytes(q);
            sent += q.size();
        end
        wait_drained();
    endtask

    initial begin
        error_count     = 0;
        cycle_count     = 0;
        hold_off_cycles = 0;
        stall_enable    = 1'b0;
        rx_fill         = 0;
        rx_idle         = 0;
        rx_timeout      = DEF_TIMEOUT;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_timeout();
        test_backpressure();
        write_timeout(16'd3);
        test_random(120);
        write_timeout(DEF_TIMEOUT);
        test_random(120);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/esp3fd_pkg.sv
rtl/esp3fd_ram.sv
rtl/esp3fd_ctrl.sv
rtl/esp3fd_dpath.sv
rtl/esp3_frame_deframer.sv
rtl/esp3fd_checker.sv
tb/tb.sv
